// ===== hdl/tcb_pkg.sv =====
// shared types, codes and helpers for the tcb spline evaluator
package tcb_pkg;

  // fixed-point formats
  localparam int FRAC   = 24;
  localparam int MUL_W  = 40;
  localparam int PROD_W = 64;
  localparam int Q_W    = 24;

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_ADVANCE = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  // one stored key
  typedef struct packed {
    logic signed [31:0] value;
    logic [31:0]        ktime;
    logic signed [15:0] tension;
    logic signed [15:0] continuity;
    logic signed [15:0] bias;
  } key_word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK_RD, ST_WALK_CHK, ST_FETCH, ST_CALC_GO, ST_CALC_WAIT, ST_EMIT
  } state_t;

  // evaluation steps, in issue order
  typedef enum logic [4:0] {
    OP_S, OP_SQ, OP_CU,
    OP_A0, OP_A1, OP_B0, OP_B1, OP_C0, OP_C1, OP_D0, OP_D1,
    OP_T0A, OP_T0B, OP_ADJ0, OP_TAN0,
    OP_T1A, OP_T1B, OP_ADJ1, OP_TAN1,
    OP_H0, OP_H1, OP_H2, OP_H3
  } op_t;

  // clamp a q1.14 parameter to minus one .. one
  function automatic logic signed [16:0] tcb_clamp(input logic signed [15:0] x);
    logic signed [16:0] v;
    v = 17'(x);
    if (v > 17'sd16384) v = 17'sd16384;
    if (v < -17'sd16384) v = -17'sd16384;
    return v;
  endfunction

  function automatic logic signed [16:0] one_plus(input logic signed [15:0] x);
    return 17'sd16384 + tcb_clamp(x);
  endfunction

  function automatic logic signed [16:0] one_minus(input logic signed [15:0] x);
    return 17'sd16384 - tcb_clamp(x);
  endfunction

endpackage

// ===== hdl/tcb_key_mem.sv =====
// key store: one write port, one registered read port
module tcb_key_mem
  import tcb_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_word_t     wdata,
  input  logic [AW-1:0] raddr,
  output key_word_t     rdata
);

  key_word_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tcb_mul.sv =====
// signed multiplier, 16 bits of the second operand per cycle, low 64 bits kept
module tcb_mul
  import tcb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic                     done,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [MUL_W-1:0] areg;
  logic signed [MUL_W-1:0] breg;
  logic [1:0]              k;
  logic                    busy;
  logic signed [16:0]      dig;
  logic signed [56:0]      pp;
  logic signed [PROD_W-1:0] pp_sh;

  // digit select and partial product, top digit carries the sign
  always_comb begin
    unique case (k)
      2'd0:    dig = $signed({1'b0, breg[15:0]});
      2'd1:    dig = $signed({1'b0, breg[31:16]});
      default: dig = 17'($signed(breg[39:32]));
    endcase
    pp    = areg * dig;
    pp_sh = PROD_W'(pp) <<< {k, 4'b0000};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= 2'd0;
      end else if (busy) begin
        k <= k + 2'd1;
        if (k == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= prod + pp_sh;
    end
  end

endmodule

// ===== hdl/tcb_div.sv =====
// restoring divider, one quotient bit per cycle, num below den
module tcb_div
  import tcb_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [31:0]    num,
  input  logic [31:0]    den,
  output logic           done,
  output logic [Q_W-1:0] quot
);

  logic [31:0] rem;
  logic [31:0] den_r;
  logic [4:0]  cnt;
  logic        busy;
  logic [32:0] r2;
  logic        ge;

  // trial subtract
  always_comb begin
    r2 = {rem, 1'b0};
    ge = (r2 >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(Q_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      quot  <= '0;
    end else if (busy) begin
      rem  <= ge ? 32'(r2 - {1'b0, den_r}) : r2[31:0];
      quot <= {quot[Q_W-2:0], ge};
    end
  end

endmodule

// ===== hdl/tcb_spline_evaluator_top.sv =====
// top level: kochanek-bartels keyframe store and evaluator
//
// Input channel (in_valid / in_stall) carries one item per request:
//   load key writes key_value, key_time and the tcb parameters at key_slot,
//   advance adds time_step to elapsed time and evaluates the curve,
//   restart clears elapsed time, segment and the finished flag.
// Load and restart give no result. An advance gives one result item on the
// output channel (out_valid / out_stall): curve_value, finished and segment.
// key_count is written through cfg_we / cfg_wdata; the user must write it
// only while the block is idle, the block itself does not enforce this.
// An advance walks the segments, one read of the key store for each key
// passed, fetches four keys, then runs the evaluation sequence on one
// shared multiplier (20 products) and one shared divider (3 quotients, each
// set directly where no division is needed). A finished curve answers after
// the walk check alone.
// One advance is worked on at a time; in_stall is high until it is done.
// The result sits in an output register, so a stalled receiver holds only
// the next advance back. Reset clears elapsed time, segment (to one), the
// finished flag, key_count (to 4) and out_valid; keys are not cleared.
module tcb_spline_evaluator_top
  import tcb_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [5:0]         key_slot,
  input  logic signed [31:0] key_value,
  input  logic [31:0]        key_time,
  input  logic signed [15:0] key_tension,
  input  logic signed [15:0] key_continuity,
  input  logic signed [15:0] key_bias,
  input  logic [31:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] curve_value,
  output logic               finished,
  output logic [5:0]         segment,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata
);

  localparam int IW = $clog2(MAX_KEYS);
  localparam int CW = ($clog2(MAX_KEYS + 1) > 7) ? $clog2(MAX_KEYS + 1) : 7;
  localparam logic [24:0] ONE = 25'(1) << FRAC;

  state_t state, state_next;
  op_t    op;

  logic [6:0]    key_count;
  logic [31:0]   elapsed;
  logic [IW-1:0] seg;
  logic          ended;
  logic [2:0]    fc;

  // fetched keys
  logic [31:0]        tp, t2;
  logic signed [31:0] pp, p2;
  key_word_t          kw_i, kw_n;

  // evaluation registers
  logic [24:0]               s_q, sq, cu, adj;
  logic [30:0]               tmp;
  logic [27:0]               dd0a, dd0b, ds1a, ds1b;
  logic signed [PROD_W-1:0]  part, acc;
  logic signed [MUL_W-1:0]   sum0, sum1, tan0, tan1;

  // memory and unit ports
  logic          mem_we;
  logic [IW-1:0] raddr;
  key_word_t     rdata, wdata;
  logic          mul_start, mul_done, div_start, div_done;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [31:0]   div_num, div_den;
  logic [Q_W-1:0] div_q;

  logic          in_acc, out_free;
  logic [CW-1:0] cnt, last, seg_ext, k2c;
  logic [32:0]   esum;
  logic signed [32:0] len, u, span_a, span_b, dp, dl, dn;
  logic signed [27:0] sq_s, cu_s, s_s, z, h00, h01, h10, h11;
  logic          op_is_div, op_last, div_special, step_done;
  logic [24:0]   div_special_val;
  logic signed [PROD_W-1:0] psum, rnd;
  logic signed [39:0] res40;
  logic signed [31:0] res_sat;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // effective key count
  always_comb begin
    if (key_count < 7'd4) begin
      cnt = CW'(4);
    end else if (32'(key_count) > MAX_KEYS) begin
      cnt = CW'(MAX_KEYS);
    end else begin
      cnt = CW'(key_count);
    end
    last    = cnt - CW'(1);
    seg_ext = CW'(seg);
    k2c     = (seg_ext + CW'(2) < cnt) ? seg_ext + CW'(2) : last;
  end

  // key store
  assign wdata = '{value: key_value, ktime: key_time, tension: key_tension,
                   continuity: key_continuity, bias: key_bias};

  tcb_key_mem #(.DEPTH(MAX_KEYS), .AW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (IW'(key_slot)),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  tcb_mul u_mul (
    .clk (clk), .rst (rst), .start (mul_start), .a (mul_a), .b (mul_b),
    .done (mul_done), .prod (mul_p)
  );

  tcb_div u_div (
    .clk (clk), .rst (rst), .start (div_start), .num (div_num), .den (div_den),
    .done (div_done), .quot (div_q)
  );

  // segment differences
  always_comb begin
    esum   = {1'b0, elapsed} + {1'b0, time_step};
    len    = $signed({1'b0, kw_n.ktime}) - $signed({1'b0, kw_i.ktime});
    u      = $signed({1'b0, elapsed}) - $signed({1'b0, kw_i.ktime});
    span_a = $signed({1'b0, kw_n.ktime}) - $signed({1'b0, tp});
    span_b = $signed({1'b0, t2}) - $signed({1'b0, kw_i.ktime});
    dp     = 33'(kw_i.value) - 33'(pp);
    dl     = 33'(kw_n.value) - 33'(kw_i.value);
    dn     = 33'(p2) - 33'(kw_n.value);
  end

  // hermite basis
  always_comb begin
    sq_s = $signed({3'b000, sq});
    cu_s = $signed({3'b000, cu});
    s_s  = $signed({3'b000, s_q});
    z    = 28'sd3 * sq_s - 28'sd2 * cu_s;
    h00  = $signed({3'b000, ONE}) - z;
    h01  = z;
    h10  = cu_s - 28'sd2 * sq_s + s_s;
    h11  = cu_s - sq_s;
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (op)
      OP_SQ:   begin mul_a = MUL_W'(s_s); mul_b = MUL_W'(s_s); end
      OP_CU:   begin mul_a = MUL_W'(s_s); mul_b = MUL_W'(sq_s); end
      OP_A0:   begin mul_a = MUL_W'(one_minus(kw_i.tension));
                     mul_b = MUL_W'(one_plus(kw_i.continuity)); end
      OP_A1:   begin mul_a = MUL_W'(tmp); mul_b = MUL_W'(one_plus(kw_i.bias)); end
      OP_B0:   begin mul_a = MUL_W'(one_minus(kw_i.tension));
                     mul_b = MUL_W'(one_minus(kw_i.continuity)); end
      OP_B1:   begin mul_a = MUL_W'(tmp); mul_b = MUL_W'(one_minus(kw_i.bias)); end
      OP_C0:   begin mul_a = MUL_W'(one_minus(kw_n.tension));
                     mul_b = MUL_W'(one_minus(kw_n.continuity)); end
      OP_C1:   begin mul_a = MUL_W'(tmp); mul_b = MUL_W'(one_plus(kw_n.bias)); end
      OP_D0:   begin mul_a = MUL_W'(one_minus(kw_n.tension));
                     mul_b = MUL_W'(one_plus(kw_n.continuity)); end
      OP_D1:   begin mul_a = MUL_W'(tmp); mul_b = MUL_W'(one_minus(kw_n.bias)); end
      OP_T0A:  begin mul_a = MUL_W'(dd0a); mul_b = MUL_W'(dp); end
      OP_T0B:  begin mul_a = MUL_W'(dd0b); mul_b = MUL_W'(dl); end
      OP_TAN0: begin mul_a = MUL_W'(adj); mul_b = sum0; end
      OP_T1A:  begin mul_a = MUL_W'(ds1a); mul_b = MUL_W'(dl); end
      OP_T1B:  begin mul_a = MUL_W'(ds1b); mul_b = MUL_W'(dn); end
      OP_TAN1: begin mul_a = MUL_W'(adj); mul_b = sum1; end
      OP_H0:   begin mul_a = MUL_W'(h00); mul_b = MUL_W'(kw_i.value); end
      OP_H1:   begin mul_a = MUL_W'(h01); mul_b = MUL_W'(kw_n.value); end
      OP_H2:   begin mul_a = MUL_W'(h10); mul_b = tan0; end
      OP_H3:   begin mul_a = MUL_W'(h11); mul_b = tan1; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // divider operands and the cases that need no division
  always_comb begin
    op_is_div       = (op == OP_S) || (op == OP_ADJ0) || (op == OP_ADJ1);
    op_last         = (op == OP_H3);
    div_num         = len[31:0];
    div_den         = span_a[31:0];
    div_special     = 1'b0;
    div_special_val = '0;
    if (op == OP_S) begin
      div_num = u[31:0];
      div_den = len[31:0];
      if (len <= 0 || u <= 0) begin
        div_special = 1'b1;
      end else if (u >= len) begin
        div_special     = 1'b1;
        div_special_val = ONE;
      end
    end else begin
      if (op == OP_ADJ1) div_den = span_b[31:0];
      if (len <= 0 || (op == OP_ADJ1 ? span_b : span_a) <= 0) begin
        div_special = 1'b1;
      end else if ((op == OP_ADJ1 ? span_b : span_a) <= len) begin
        div_special     = 1'b1;
        div_special_val = ONE;
      end
    end
    step_done = op_is_div ? div_done : mul_done;
  end

  // final rounding and saturation
  always_comb begin
    psum  = part + mul_p;
    rnd   = acc + PROD_W'(64'sd1 <<< (FRAC - 1));
    res40 = rnd[63:24];
    if (res40 > 40'sd2147483647) begin
      res_sat = 32'sh7fffffff;
    end else if (res40 < -40'sd2147483648) begin
      res_sat = 32'sh80000000;
    end else begin
      res_sat = res40[31:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && req_type == REQ_ADVANCE) state_next = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = (ended || seg_ext >= last) ? ST_EMIT : ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        state_next = (elapsed > rdata.ktime) ? ST_WALK_RD : ST_FETCH;
      end
      ST_FETCH: begin
        if (fc == 3'd4) state_next = ST_CALC_GO;
      end
      ST_CALC_GO: begin
        if (op_is_div && div_special) begin
          state_next = op_last ? ST_EMIT : ST_CALC_GO;
        end else begin
          state_next = ST_CALC_WAIT;
        end
      end
      ST_CALC_WAIT: begin
        if (step_done) state_next = op_last ? ST_EMIT : ST_CALC_GO;
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    raddr     = seg + IW'(1);
    unique case (state)
      ST_IDLE: begin
        mem_we = in_valid && req_type == REQ_LOAD && 32'(key_slot) < MAX_KEYS;
      end
      ST_FETCH: begin
        unique case (fc)
          3'd0:    raddr = seg - IW'(1);
          3'd1:    raddr = seg;
          3'd2:    raddr = seg + IW'(1);
          default: raddr = IW'(k2c);
        endcase
      end
      ST_CALC_GO: begin
        mul_start = !op_is_div;
        div_start = op_is_div && !div_special;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_count <= 7'd4;
      elapsed   <= '0;
      seg       <= IW'(1);
      ended     <= 1'b0;
      fc        <= '0;
      op        <= OP_S;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) key_count <= cfg_wdata;
      // result valid: set when a result is loaded, cleared when taken
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && req_type == REQ_RESTART) begin
            elapsed <= '0;
            seg     <= IW'(1);
            ended   <= 1'b0;
          end else if (in_acc && req_type == REQ_ADVANCE) begin
            elapsed <= esum[32] ? 32'hffffffff : esum[31:0];
          end
        end
        ST_WALK_RD: begin
          if (!ended && seg_ext >= last) ended <= 1'b1;
        end
        ST_WALK_CHK: begin
          fc <= '0;
          if (elapsed > rdata.ktime) seg <= seg + IW'(1);
        end
        ST_FETCH: begin
          fc <= fc + 3'd1;
          op <= OP_S;
        end
        ST_CALC_GO: begin
          if (op_is_div && div_special && !op_last) op <= op_t'(op + 5'd1);
        end
        ST_CALC_WAIT: begin
          if (step_done && !op_last) op <= op_t'(op + 5'd1);
        end
        default: begin
          fc <= '0;
        end
      endcase
    end
  end

  // fetch capture
  always_ff @(posedge clk) begin
    if (state == ST_FETCH) begin
      unique case (fc)
        3'd1: begin tp <= rdata.ktime; pp <= rdata.value; end
        3'd2: kw_i <= rdata;
        3'd3: kw_n <= rdata;
        3'd4: begin t2 <= rdata.ktime; p2 <= rdata.value; end
        default: tp <= tp;
      endcase
    end
  end

  // evaluation write-back
  always_ff @(posedge clk) begin
    if (state == ST_CALC_GO && op_is_div && div_special) begin
      if (op == OP_S) s_q <= div_special_val;
      else            adj <= div_special_val;
    end
    if (state == ST_CALC_WAIT && step_done) begin
      unique case (op)
        OP_S:            s_q  <= {1'b0, div_q};
        OP_ADJ0, OP_ADJ1: adj <= {1'b0, div_q};
        OP_SQ:           sq   <= mul_p[48:24];
        OP_CU:           cu   <= mul_p[48:24];
        OP_A0, OP_B0, OP_C0, OP_D0: tmp <= mul_p[30:0];
        OP_A1:           dd0a <= mul_p[45:18];
        OP_B1:           dd0b <= mul_p[45:18];
        OP_C1:           ds1a <= mul_p[45:18];
        OP_D1:           ds1b <= mul_p[45:18];
        OP_T0A, OP_T1A:  part <= mul_p;
        OP_T0B:          sum0 <= psum[63:24];
        OP_T1B:          sum1 <= psum[63:24];
        OP_TAN0:         tan0 <= mul_p[63:24];
        OP_TAN1:         tan1 <= mul_p[63:24];
        OP_H0:           acc  <= mul_p;
        OP_H1, OP_H2, OP_H3: acc <= acc + mul_p;
        default:         acc  <= acc;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      curve_value <= ended ? 32'sd0 : res_sat;
      finished    <= ended;
      segment     <= 6'(seg);
    end
  end

endmodule

// ===== hdl/tcb_checker.sv =====
// port-level checks for the spline evaluator, bound to the top level
module tcb_checker
  import tcb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         req_type,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] curve_value,
  input logic               finished
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a finished curve reports zero
  a_finished_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> curve_value == 32'sd0)
    else $error("finished result with nonzero value");

  // an accepted advance holds the input side off
  a_advance_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_ADVANCE |=> in_stall)
    else $error("input taken while an advance is in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(curve_value) && $stable(finished))
    else $error("stalled result changed");

endmodule

bind tcb_spline_evaluator_top tcb_checker u_tcb_checker (.*);
